// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the rtl of the huffman bit packer
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/core/hbp_pkg.sv =====
// types and fixed constants of the huffman bit packer
// no dependencies; imported by the interfaces and the top level
package hbp_pkg;

    // fixed field widths of the channels and of the pending bits
    localparam int SYM_IN_W = 8;
    localparam int WORD_W   = 32;
    localparam int LEN_W    = 6;
    localparam int BYTE_W   = 8;
    localparam int PEND_W   = 7;

    // command codes of an input beat
    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_ENCODE = 2'd1,
        CMD_FLUSH  = 2'd2
    } cmd_t;

endpackage

// ===== rtl/core/hbp_in_if.sv =====
// command channel of the huffman bit packer: valid/ready plus payload
// depends on hbp_pkg for the command type and field widths
interface hbp_in_if
    import hbp_pkg::*;
();
    logic                valid;
    logic                ready;
    cmd_t                cmd;
    logic [SYM_IN_W-1:0] symbol;
    logic [WORD_W-1:0]   code_word;
    logic [LEN_W-1:0]    code_length;

    modport source (
        output valid, cmd, symbol, code_word, code_length,
        input  ready
    );

    modport sink (
        input  valid, cmd, symbol, code_word, code_length,
        output ready
    );
endinterface

// ===== rtl/core/hbp_out_if.sv =====
// byte channel of the huffman bit packer: valid/ready plus payload
// depends on hbp_pkg for the byte width
interface hbp_out_if
    import hbp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              last_in_run;
    logic              end_of_message;

    modport source (
        output valid, out_byte, last_in_run, end_of_message,
        input  ready
    );

    modport sink (
        input  valid, out_byte, last_in_run, end_of_message,
        output ready
    );
endinterface

// ===== rtl/core/hbp_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module hbp_ram #(
    parameter int  WIDTH  = 38,
    parameter int  DEPTH  = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [ADDR_W-1:0]        waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [ADDR_W-1:0]        raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== rtl/core/huffman_bit_packer_top.sv =====
// huffman bit packer: code table in ram, bit accumulator, byte output register
// path: an encode beat passes the lookup stage, the bit accumulator and the output register before its first byte shows
// throughput: one beat per cycle while each beat yields at most one byte and byte_ch is ready;
//   after a beat yielding more bytes (up to 4), the next waits on the one-byte-per-cycle emitter
// reset: clears the accumulator bit count and the per-entry valid flags, so every table
//   entry reads as length zero at once; no clearing pass. depends on hbp_pkg, hbp_ram
`include "assert_macros.svh"

module huffman_bit_packer_top
    import hbp_pkg::*;
#(
    parameter int NUM_SYMBOLS  = 256,
    parameter int MAX_CODE_LEN = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    hbp_in_if.sink    cmd_ch,
    hbp_out_if.source byte_ch
);
    localparam int SYM_W   = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
    localparam int CLEN_W  = $clog2(MAX_CODE_LEN + 1);
    localparam int ENTRY_W = MAX_CODE_LEN + CLEN_W;
    localparam int ACC_W   = MAX_CODE_LEN + PEND_W;
    localparam int CNT_W   = $clog2(ACC_W + 1);

    // command decode
    logic is_load;
    logic is_encode;
    logic is_flush;
    logic in_fire;
    logic in_range;
    logic [SYM_W-1:0] addr;

    always_comb
    begin
        is_load   = 1'b0;
        is_encode = 1'b0;
        is_flush  = 1'b0;
        unique case (cmd_ch.cmd)
            CMD_LOAD:   is_load   = 1'b1;
            CMD_ENCODE: is_encode = 1'b1;
            CMD_FLUSH:  is_flush  = 1'b1;
            default:    ;
        endcase
    end

    assign in_fire  = cmd_ch.valid && cmd_ch.ready;
    assign in_range = {1'b0, cmd_ch.symbol} < (SYM_IN_W + 1)'(NUM_SYMBOLS);
    assign addr     = cmd_ch.symbol[SYM_W-1:0];

    // table load: clamp length and drop code bits above it
    logic [CLEN_W-1:0]       len_clamp;
    logic [MAX_CODE_LEN-1:0] ones;
    logic [MAX_CODE_LEN-1:0] code_mask;
    logic [ENTRY_W-1:0]      wdata;
    logic                    we;

    assign len_clamp = (cmd_ch.code_length > LEN_W'(MAX_CODE_LEN))
                     ? CLEN_W'(MAX_CODE_LEN) : cmd_ch.code_length[CLEN_W-1:0];
    assign ones      = '1;
    assign code_mask = ~(ones << len_clamp);
    assign wdata     = {len_clamp, cmd_ch.code_word[MAX_CODE_LEN-1:0] & code_mask};
    assign we        = in_fire && is_load && in_range;

    // per-entry valid flags, an unwritten entry reads as length zero
    logic [NUM_SYMBOLS-1:0] valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (we)
        begin
            valid_reg[addr] <= 1'b1;
        end
    end

    // code table
    logic [ENTRY_W-1:0] rdata;

    hbp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_SYMBOLS)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (addr),
        .wdata (wdata),
        .re    (in_fire && is_encode),
        .raddr (addr),
        .rdata (rdata)
    );

    // lookup stage: holds an encode or flush beat while the table read completes and until the accumulator absorbs it
    logic s1_valid_reg;
    logic s1_valid_next;
    logic s1_flush_reg;
    logic s1_hit_reg;
    logic absorb;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire && (is_encode || is_flush))
        begin
            s1_valid_next = 1'b1;
        end
        else if (absorb)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_flush_reg <= is_flush;
            s1_hit_reg   <= in_range && valid_reg[addr];
        end
    end

    assign cmd_ch.ready = !s1_valid_reg || absorb;

    // bit accumulator: bits [cnt-1:0] of acc are the ones not yet emitted
    logic [ACC_W-1:0]  acc_reg;
    logic [ACC_W-1:0]  acc_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              eom_reg;
    logic              eom_next;
    logic              out_valid_reg;
    logic              out_free;
    logic              emit;
    logic [CNT_W-1:0]  cnt_minus8;
    logic [CNT_W-1:0]  cnt_after;
    logic [2:0]        pend_cnt;
    logic [PEND_W-1:0] pend;
    logic [ACC_W-1:0]  acc_shifted;
    logic [CLEN_W-1:0]       ent_len;
    logic [MAX_CODE_LEN-1:0] ent_code;
    logic [BYTE_W-1:0]       pad_byte;

    assign out_free    = !out_valid_reg || byte_ch.ready;
    assign cnt_minus8  = cnt_reg - CNT_W'(8);
    assign emit        = (cnt_reg >= CNT_W'(8)) && out_free;
    assign cnt_after   = emit ? cnt_minus8 : cnt_reg;
    assign absorb      = s1_valid_reg && (cnt_after < CNT_W'(8));
    assign pend_cnt    = cnt_after[2:0];
    assign pend        = acc_reg[PEND_W-1:0] & ~({PEND_W{1'b1}} << pend_cnt);
    assign acc_shifted = acc_reg >> cnt_minus8;

    // table entry, zero when the symbol was never loaded or is out of range
    assign ent_len  = s1_hit_reg ? rdata[ENTRY_W-1:MAX_CODE_LEN] : '0;
    assign ent_code = s1_hit_reg ? rdata[MAX_CODE_LEN-1:0] : '0;
    assign pad_byte = BYTE_W'({1'b0, pend} << (4'd8 - {1'b0, pend_cnt}));

    // merge the beat in the lookup stage into the pending bits, or pad them to a byte on a flush
    always_comb
    begin
        acc_next = acc_reg;
        cnt_next = cnt_after;
        eom_next = eom_reg;
        if (absorb)
        begin
            eom_next = s1_flush_reg;
            if (s1_flush_reg)
            begin
                acc_next = ACC_W'(pad_byte);
                cnt_next = (pend_cnt != 3'd0) ? CNT_W'(8) : '0;
            end
            else
            begin
                acc_next = (ACC_W'(pend) << ent_len) | ACC_W'(ent_code);
                cnt_next = CNT_W'(pend_cnt) + CNT_W'(ent_len);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            eom_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            eom_reg <= eom_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    // output register, one byte beat per cycle while the byte channel is ready
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_last_reg;
    logic              out_eom_reg;
    logic              emit_last;

    assign emit_last = cnt_minus8 < CNT_W'(8);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (byte_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg <= acc_shifted[BYTE_W-1:0];
            out_last_reg <= emit_last;
            out_eom_reg  <= eom_reg && emit_last;
        end
    end

    assign byte_ch.valid          = out_valid_reg;
    assign byte_ch.out_byte       = out_byte_reg;
    assign byte_ch.last_in_run    = out_last_reg;
    assign byte_ch.end_of_message = out_eom_reg;

    // checks
    `ASSERT_SAME(a_absorb_room, clk, rst_n, absorb, (cnt_reg < CNT_W'(8)) || emit)
    `ASSERT_SAME(a_eom_is_last, clk, rst_n, byte_ch.valid && byte_ch.end_of_message, byte_ch.last_in_run)
    `ASSERT_NEXT(a_flush_pads, clk, rst_n, absorb && s1_flush_reg, (cnt_reg == '0) || (cnt_reg == CNT_W'(8)))
    `ASSERT_NEXT(a_emit_shows, clk, rst_n, emit, byte_ch.valid)
endmodule

// ===== verif/tb_huffman_bit_packer_top.sv =====
// self-checking testbench of huffman_bit_packer_top: random and directed command beats
// a bit-level predictor checks every byte; depends on hbp_pkg, hbp_in_if, hbp_out_if
`timescale 1ns / 1ps

module tb_huffman_bit_packer_top;
    import hbp_pkg::*;

    localparam int N_SYM      = 256;
    localparam int MAX_LEN    = 32;
    localparam int RAND_BEATS = 410;
    localparam int CYC_LIMIT  = 200000;
    localparam int TAIL_CYC   = 12;

    // command code that the block must ignore
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        RDY_FULL,
        RDY_HALF,
        RDY_SPARSE,
        RDY_PERIODIC
    } rdy_mode_t;

    typedef struct {
        cmd_t                cmd;
        logic [SYM_IN_W-1:0] symbol;
        logic [WORD_W-1:0]   code_word;
        logic [LEN_W-1:0]    code_length;
        bit                  drain;
    } cmd_beat_t;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              eom;
    } byte_beat_t;

    logic clk = 1'b0;
    logic rst_n;

    hbp_in_if  cmd_ch ();
    hbp_out_if byte_ch ();

    huffman_bit_packer_top #(
        .NUM_SYMBOLS  (N_SYM),
        .MAX_CODE_LEN (MAX_LEN)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd_ch  (cmd_ch),
        .byte_ch (byte_ch)
    );

    // stimulus and expectations
    cmd_beat_t  cmd_beats[$];
    byte_beat_t exp_bytes[$];
    logic [7:0] live_syms[$];

    // predictor state
    logic [WORD_W-1:0] code_mem [N_SYM];
    int unsigned       len_mem  [N_SYM];
    logic [PEND_W-1:0] pend_bits;
    int unsigned       pend_cnt;

    logic        cmd_taken;
    int          n_err;
    int          cyc;
    int          gap_left;
    int          burst_left;
    int          mode_left;
    rdy_mode_t   rdy_mode;

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // cycle limit
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc == CYC_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic add_beat(input cmd_t c, input logic [7:0] s, input logic [31:0] w,
                            input logic [5:0] l, input bit drain);
        cmd_beat_t b;
        b.cmd         = c;
        b.symbol      = s;
        b.code_word   = w;
        b.code_length = l;
        b.drain       = drain;
        cmd_beats.push_back(b);
    endtask

    // expected bytes of one accepted command beat
    task automatic predict_bytes(input cmd_t c, input logic [7:0] s, input logic [31:0] w,
                                 input logic [5:0] l);
        int unsigned clen;
        int unsigned total;
        logic [63:0] acc;
        logic [63:0] mask;
        byte_beat_t  b;
        clen = 0;
        case (c)
            CMD_LOAD:
            begin
                if (s < N_SYM)
                begin
                    clen = (l > MAX_LEN) ? MAX_LEN : l;
                    mask = (64'd1 << clen) - 64'd1;
                    len_mem[s]  = clen;
                    code_mem[s] = w & mask[31:0];
                end
            end
            CMD_ENCODE:
            begin
                acc = 64'd0;
                if (s < N_SYM)
                begin
                    clen = len_mem[s];
                    acc  = {32'd0, code_mem[s]};
                end
                acc   = ({57'd0, pend_bits} << clen) | acc;
                total = pend_cnt + clen;
                while (total >= 8)
                begin
                    b.data = 8'(acc >> (total - 8));
                    total  = total - 8;
                    b.last = (total < 8);
                    b.eom  = 1'b0;
                    exp_bytes.push_back(b);
                end
                mask      = (64'd1 << total) - 64'd1;
                pend_bits = 7'(acc & mask);
                pend_cnt  = total;
            end
            CMD_FLUSH:
            begin
                if (pend_cnt > 0)
                begin
                    b.data = 8'({1'b0, pend_bits} << (8 - pend_cnt));
                    b.last = 1'b1;
                    b.eom  = 1'b1;
                    exp_bytes.push_back(b);
                end
                pend_bits = '0;
                pend_cnt  = 0;
            end
            default:
            begin
            end
        endcase
    endtask

    // output check first, then prediction of the beat taken at this edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_taken <= 1'b0;
            for (int i = 0; i < N_SYM; i++)
            begin
                code_mem[i] = '0;
                len_mem[i]  = 0;
            end
            pend_bits = '0;
            pend_cnt  = 0;
            exp_bytes.delete();
        end
        else
        begin
            if (byte_ch.valid && byte_ch.ready)
            begin
                if (exp_bytes.size() == 0)
                begin
                    n_err++;
                    $display("%0t: unexpected byte: expected none, got %h last %b eom %b",
                             $time, byte_ch.out_byte, byte_ch.last_in_run,
                             byte_ch.end_of_message);
                end
                else
                begin
                    if (byte_ch.out_byte !== exp_bytes[0].data)
                    begin
                        n_err++;
                        $display("%0t: out_byte mismatch: expected %h, got %h",
                                 $time, exp_bytes[0].data, byte_ch.out_byte);
                    end
                    if (byte_ch.last_in_run !== exp_bytes[0].last)
                    begin
                        n_err++;
                        $display("%0t: last_in_run mismatch: expected %b, got %b",
                                 $time, exp_bytes[0].last, byte_ch.last_in_run);
                    end
                    if (byte_ch.end_of_message !== exp_bytes[0].eom)
                    begin
                        n_err++;
                        $display("%0t: end_of_message mismatch: expected %b, got %b",
                                 $time, exp_bytes[0].eom, byte_ch.end_of_message);
                    end
                    exp_bytes.delete(0);
                end
            end
            cmd_taken <= cmd_ch.valid && cmd_ch.ready;
            if (cmd_ch.valid && cmd_ch.ready)
                predict_bytes(cmd_ch.cmd, cmd_ch.symbol, cmd_ch.code_word, cmd_ch.code_length);
        end
    end

    // command driver: bursts and gaps, drain beats wait for all bytes out
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            cmd_ch.valid <= 1'b0;
        end
        else
        begin
            if (cmd_taken)
            begin
                cmd_beats.delete(0);
                burst_left--;
                if (burst_left <= 0)
                begin
                    if ($urandom_range(0, 3) == 0)
                    begin
                        gap_left   = 0;
                        burst_left = $urandom_range(30, 80);
                    end
                    else
                    begin
                        gap_left   = $urandom_range(1, 8);
                        burst_left = $urandom_range(1, 12);
                    end
                end
            end
            if (cmd_ch.valid && !cmd_taken)
            begin
                // beat still pending, hold it
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                cmd_ch.valid <= 1'b0;
            end
            else if (cmd_beats.size() > 0 && !(cmd_beats[0].drain && exp_bytes.size() > 0))
            begin
                cmd_ch.valid       <= 1'b1;
                cmd_ch.cmd         <= cmd_beats[0].cmd;
                cmd_ch.symbol      <= cmd_beats[0].symbol;
                cmd_ch.code_word   <= cmd_beats[0].code_word;
                cmd_ch.code_length <= cmd_beats[0].code_length;
            end
            else
            begin
                cmd_ch.valid <= 1'b0;
            end
        end
    end

    // byte receiver: stall pattern switches mode every so often
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            byte_ch.ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                rdy_mode  = rdy_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 160);
            end
            else
            begin
                mode_left--;
            end
            case (rdy_mode)
                RDY_FULL:     byte_ch.ready <= 1'b1;
                RDY_HALF:     byte_ch.ready <= 1'($urandom_range(0, 1));
                RDY_SPARSE:   byte_ch.ready <= ($urandom_range(0, 3) == 0);
                default:      byte_ch.ready <= ((mode_left % 12) < 3);
            endcase
        end
    end

    initial
    begin
        int          n_rand;
        int          msg;
        int          n_ld;
        int          n_enc;
        int          r;
        bit          msg_drain;
        logic [7:0]  s;
        logic [5:0]  l;

        // known levels on every input from time zero
        rst_n              = 1'b0;
        cmd_ch.valid       = 1'b0;
        cmd_ch.cmd         = CMD_LOAD;
        cmd_ch.symbol      = '0;
        cmd_ch.code_word   = '0;
        cmd_ch.code_length = '0;
        byte_ch.ready      = 1'b0;
        n_err      = 0;
        cyc        = 0;
        gap_left   = 0;
        burst_left = 6;
        mode_left  = 0;
        rdy_mode   = RDY_FULL;

        // directed: empty flush, unloaded symbol, unused command
        add_beat(CMD_FLUSH, 8'd0, 32'd0, 6'd0, 1'b0);
        add_beat(CMD_ENCODE, 8'd7, 32'd0, 6'd0, 1'b0);
        add_beat(cmd_t'(CMD_UNUSED), 8'hff, 32'hffff_ffff, 6'd63, 1'b0);
        // table loads: overlong lengths, zero length, field extremes
        add_beat(CMD_LOAD, 8'd255, 32'hffff_ffff, 6'd63, 1'b0);
        add_beat(CMD_LOAD, 8'd0, 32'h0000_0000, 6'd1, 1'b0);
        add_beat(CMD_LOAD, 8'd1, 32'h0000_00a5, 6'd8, 1'b0);
        add_beat(CMD_LOAD, 8'd2, 32'h0000_0005, 6'd3, 1'b0);
        add_beat(CMD_LOAD, 8'd3, 32'hdead_beef, 6'd0, 1'b0);
        add_beat(CMD_LOAD, 8'd4, 32'hffff_ffff, 6'd33, 1'b0);
        add_beat(CMD_LOAD, 8'd5, 32'hffff_ff81, 6'd7, 1'b0);
        // encodes up to four bytes per beat, zero-length symbol, exact byte
        add_beat(CMD_ENCODE, 8'd2, 32'd0, 6'd0, 1'b0);
        add_beat(CMD_ENCODE, 8'd2, 32'd0, 6'd0, 1'b0);
        add_beat(CMD_ENCODE, 8'd255, 32'd0, 6'd0, 1'b0);
        add_beat(CMD_ENCODE, 8'd0, 32'd0, 6'd0, 1'b0);
        add_beat(CMD_ENCODE, 8'd4, 32'd0, 6'd0, 1'b0);
        add_beat(CMD_ENCODE, 8'd3, 32'd0, 6'd0, 1'b0);
        add_beat(CMD_ENCODE, 8'd1, 32'd0, 6'd0, 1'b0);
        add_beat(CMD_FLUSH, 8'd0, 32'd0, 6'd0, 1'b0);
        add_beat(CMD_FLUSH, 8'd0, 32'd0, 6'd0, 1'b0);
        add_beat(CMD_ENCODE, 8'd1, 32'd0, 6'd0, 1'b0);
        add_beat(CMD_FLUSH, 8'd0, 32'd0, 6'd0, 1'b0);
        add_beat(CMD_LOAD, 8'd1, 32'd0, 6'd0, 1'b0);
        add_beat(CMD_ENCODE, 8'd1, 32'd0, 6'd0, 1'b0);
        add_beat(CMD_ENCODE, 8'd5, 32'd0, 6'd0, 1'b0);
        add_beat(CMD_ENCODE, 8'd255, 32'd0, 6'd0, 1'b0);
        add_beat(CMD_FLUSH, 8'd0, 32'd0, 6'd0, 1'b0);

        // random messages: a few loads, encodes mostly of loaded symbols, usually a flush
        n_rand = 0;
        msg    = 0;
        while (n_rand < RAND_BEATS)
        begin
            msg_drain = (msg == 3) || ($urandom_range(0, 11) == 0);
            n_ld      = (msg == 0) ? $urandom_range(2, 8) : $urandom_range(0, 6);
            for (int i = 0; i < n_ld; i++)
            begin
                s = 8'($urandom_range(0, 255));
                r = $urandom_range(0, 9);
                if (r == 0)
                    l = 6'd0;
                else if (r == 1)
                    l = 6'($urandom_range(33, 63));
                else if (r <= 3)
                    l = 6'($urandom_range(17, 32));
                else
                    l = 6'($urandom_range(1, 16));
                add_beat(CMD_LOAD, s, $urandom, l, msg_drain);
                msg_drain = 1'b0;
                if (l != 0)
                    live_syms.push_back(s);
                n_rand++;
            end
            n_enc = $urandom_range(1, 24);
            for (int i = 0; i < n_enc; i++)
            begin
                r = $urandom_range(0, 15);
                if (live_syms.size() == 0 || r == 1)
                    s = 8'($urandom_range(0, 255));
                else
                    s = live_syms[$urandom_range(0, live_syms.size() - 1)];
                if (r == 0)
                    add_beat(cmd_t'(CMD_UNUSED), 8'($urandom_range(0, 255)), $urandom,
                             6'($urandom_range(0, 63)), msg_drain);
                else
                    add_beat(CMD_ENCODE, s, $urandom, 6'($urandom_range(0, 63)), msg_drain);
                msg_drain = 1'b0;
                n_rand++;
            end
            if ($urandom_range(0, 5) != 0)
            begin
                add_beat(CMD_FLUSH, 8'($urandom_range(0, 255)), $urandom,
                         6'($urandom_range(0, 63)), msg_drain);
                n_rand++;
            end
            msg++;
        end

        // hold reset, then release it away from the active edge
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // run until every beat is taken and every byte is out
        @(posedge clk);
        while (cmd_beats.size() != 0 || cmd_ch.valid || exp_bytes.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYC) @(posedge clk);

        if (n_err == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/hbp_pkg.sv
rtl/core/hbp_in_if.sv
rtl/core/hbp_out_if.sv
rtl/core/hbp_ram.sv
rtl/core/huffman_bit_packer_top.sv
verif/tb_huffman_bit_packer_top.sv
